// ----- rtl/core/tpaf_pkg.sv -----
// ----------------------------------------------------------------------------
// tpaf_pkg
// shared types and constants of the triac phase-angle firing controller
// ----------------------------------------------------------------------------
package tpaf_pkg;

  // request codes carried by req_type
  localparam logic [2:0] REQ_TICK  = 3'd0;
  localparam logic [2:0] REQ_EDGE  = 3'd1;
  localparam logic [2:0] REQ_START = 3'd2;
  localparam logic [2:0] REQ_STOP  = 3'd3;
  localparam logic [2:0] REQ_SET   = 3'd4;

  // configuration register indexes
  localparam logic [2:0] CFG_MAINS_SIXTY_HZ = 3'd0;
  localparam logic [2:0] CFG_GATE_PULSE_US  = 3'd1;
  localparam logic [2:0] CFG_MIN_PERCENT    = 3'd2;
  localparam logic [2:0] CFG_MAX_PERCENT    = 3'd3;
  localparam logic [2:0] CFG_MAX_SPEED_RPM  = 3'd4;

  // reset values of the configuration registers
  localparam logic [13:0] RST_GATE_PULSE_US = 14'd100;
  localparam logic [14:0] RST_MIN_PERCENT   = 15'd0;
  localparam logic [14:0] RST_MAX_PERCENT   = 15'd25600;
  localparam logic [15:0] RST_MAX_SPEED_RPM = 16'd1500;

  // mains half cycles in microseconds
  localparam logic [13:0] HALF_50 = 14'd10000;
  localparam logic [13:0] HALF_60 = 14'd8333;

  // percent full scale in units of 1/256 percent, and 1.0 in Q1.16
  localparam logic [16:0] PCT_FULL = 17'd25600;
  localparam logic [16:0] X_ONE    = 17'h10000;

  // shared divider widths
  localparam int DIV_W = 32;
  localparam int DVS_W = 16;

  typedef struct packed {
    logic busy;
    logic done;
  } tpaf_div_stat_t;

endpackage

// ----- rtl/core/tpaf_div.sv -----
// ----------------------------------------------------------------------------
// tpaf_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module tpaf_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [tpaf_pkg::DIV_W-1:0] dividend,
  input  logic [tpaf_pkg::DVS_W-1:0] divisor,
  output logic [tpaf_pkg::DIV_W-1:0] quotient,
  output tpaf_pkg::tpaf_div_stat_t   stat
);
  import tpaf_pkg::*;

  localparam int CNT_W = $clog2(DIV_W);

  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [DIV_W-1:0] quo;
  logic [CNT_W-1:0] count;
  logic             busy;
  logic             done;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             fits;

  assign trial = {rem, quo[DIV_W-1]};
  assign fits  = (trial >= {1'b0, dvs});
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CNT_W'(DIV_W - 1);
        rem   <= '0;
        quo   <= dividend;
        dvs   <= divisor;
      end else if (busy) begin
        if (fits) begin
          rem <= diff[DVS_W-1:0];
        end else begin
          rem <= trial[DVS_W-1:0];
        end
        quo <= {quo[DIV_W-2:0], fits};
        if (count == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          count <= count - CNT_W'(1);
        end
      end
    end
  end

  assign quotient  = quo;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// ----- rtl/core/triac_phase_angle_firing_top.sv -----
// ----------------------------------------------------------------------------
// triac_phase_angle_firing_top
// phase-angle firing controller: tick-driven delay and gate pulse timing,
// zero-cross debounce, and speed-to-delay mapping on a shared mul/div unit
// ----------------------------------------------------------------------------
//
// channel   direction  handshake            payload
// in        input      in_valid / in_stall   req_type, target_speed_rpm
// out       output     out_valid / out_stall gate_level, is_running,
//                                            fire_pending, firing_delay_us,
//                                            edge_accepted
// cfg       input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// for tick, edge, start, stop and unknown requests, the word is taken and
// its result is loaded at the same edge
// set target runs the sequencer from S_PMUL to S_CAP, with two passes through
// the shared restoring divider (one when max_percent <= min_percent)
// a new word is taken in the cycle the previous result leaves, so a stall on
// out holds off in, and in stays stalled while a set target is in flight
// rst is synchronous; it restores register defaults and clears the controller
module triac_phase_angle_firing_top #(
  parameter int SAFETY_MARGIN_US = 200,
  parameter int TIME_BITS        = 16
) (
  input  logic        clk,
  input  logic        rst,
  // input words
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  req_type,
  input  logic [15:0] target_speed_rpm,
  // result words
  output logic        out_valid,
  input  logic        out_stall,
  output logic        gate_level,
  output logic        is_running,
  output logic        fire_pending,
  output logic [13:0] firing_delay_us,
  output logic        edge_accepted,
  // register writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import tpaf_pkg::*;

  // delay caps and debounce windows for both mains frequencies
  localparam logic [13:0] CAP_50 = 14'(10000 - SAFETY_MARGIN_US);
  localparam logic [13:0] CAP_60 = 14'(8333 - SAFETY_MARGIN_US);
  localparam logic [TIME_BITS-1:0] THIRD_50 = TIME_BITS'(10000 / 3);
  localparam logic [TIME_BITS-1:0] THIRD_60 = TIME_BITS'(8333 / 3);

  // sequencer for the speed-to-delay mapping
  typedef enum logic [3:0] {
    S_IDLE,
    S_PMUL,   // rpm * 25600
    S_PDIV,   // start percent division
    S_PWAIT,  // wait, then clamp percent
    S_XDIV,   // start fraction division, or take x = 1
    S_XWAIT,  // wait for x
    S_SQ,     // x * x
    S_INV,    // (1 - x^2) * half
    S_CAP     // cap and write delay
  } state_t;

  state_t state;

  // configuration registers
  logic        mains_sixty_hz;
  logic [13:0] gate_pulse_us;
  logic [14:0] min_percent;
  logic [14:0] max_percent;
  logic [15:0] max_speed_rpm;

  // controller state
  logic                 running_flag, running_flag_next;
  logic [13:0]          delay_value;
  logic [TIME_BITS-1:0] since_last_edge, since_last_edge_next;
  logic                 seen_edge, seen_edge_next;
  logic [13:0]          delay_countdown, delay_countdown_next;
  logic                 pending_flag, pending_flag_next;
  logic [13:0]          pulse_countdown, pulse_countdown_next;
  logic                 gate_out, gate_out_next;
  logic                 accepted, accepted_next;

  // datapath registers
  logic [15:0] rpm;
  logic [14:0] p_clamp;
  logic [16:0] x;
  logic [33:0] prod;

  // shared multiplier and divider
  logic [16:0]          mul_a;
  logic [16:0]          mul_b;
  logic [33:0]          mul_p;
  logic                 div_start;
  logic [DIV_W-1:0]     div_dividend;
  logic [DVS_W-1:0]     div_divisor;
  logic [DIV_W-1:0]     div_quo;
  tpaf_div_stat_t       div_stat;

  logic                 in_acc;
  logic [13:0]          half;
  logic [13:0]          cap;
  logic [TIME_BITS-1:0] third;
  logic                 ignore_edge;
  logic [15:0]          scale;
  logic                 span_ok;
  logic [31:0]          p_lo;
  logic [31:0]          p_hi;
  logic [17:0]          d_raw;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE) || (out_valid && out_stall);
  assign in_acc    = in_valid && !in_stall;

  assign half  = mains_sixty_hz ? HALF_60 : HALF_50;
  assign cap   = mains_sixty_hz ? CAP_60 : CAP_50;
  assign third = mains_sixty_hz ? THIRD_60 : THIRD_50;
  assign scale = (max_speed_rpm == 16'd0) ? 16'd1 : max_speed_rpm;

  // limits leave a usable range only when max is above min
  assign span_ok = (max_percent > min_percent);

  // debounce: too soon after the previous edge
  assign ignore_edge = seen_edge && (since_last_edge < third);

  // percent clamp, low limit first and then high limit
  assign p_lo = (div_quo < {17'd0, min_percent}) ? {17'd0, min_percent} : div_quo;
  assign p_hi = (p_lo > {17'd0, max_percent}) ? {17'd0, max_percent} : p_lo;

  assign d_raw = prod[33:16];

  // multiplier operand select
  always_comb begin
    case (state)
      S_PMUL: begin
        mul_a = {1'b0, rpm};
        mul_b = PCT_FULL;
      end
      S_SQ: begin
        mul_a = x;
        mul_b = x;
      end
      S_INV: begin
        mul_a = X_ONE - prod[32:16];
        mul_b = {3'd0, half};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = {17'd0, mul_a} * {17'd0, mul_b};

  // divider operands: percent first, then normalized fraction
  assign div_start    = (state == S_PDIV) || ((state == S_XDIV) && span_ok);
  assign div_dividend = (state == S_PDIV) ? prod[31:0]
                                          : {1'b0, p_clamp - min_percent, 16'd0};
  assign div_divisor  = (state == S_PDIV) ? scale
                                          : {1'b0, max_percent - min_percent};

  tpaf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quo),
    .stat     (div_stat)
  );

  // tick, edge, start and stop requests
  always_comb begin
    running_flag_next    = running_flag;
    since_last_edge_next = since_last_edge;
    seen_edge_next       = seen_edge;
    delay_countdown_next = delay_countdown;
    pending_flag_next    = pending_flag;
    pulse_countdown_next = pulse_countdown;
    gate_out_next        = gate_out;
    accepted_next        = accepted;
    if (in_acc) begin
      accepted_next = 1'b0;
      case (req_type)
        REQ_TICK: begin
          if (since_last_edge != '1) begin
            since_last_edge_next = since_last_edge + TIME_BITS'(1);
          end
          // pulse first, then delay
          if (pulse_countdown != 14'd0) begin
            pulse_countdown_next = pulse_countdown - 14'd1;
            if (pulse_countdown == 14'd1) begin
              gate_out_next = 1'b0;
            end
          end
          if (pending_flag) begin
            if (delay_countdown > 14'd1) begin
              delay_countdown_next = delay_countdown - 14'd1;
            end else begin
              delay_countdown_next = 14'd0;
              gate_out_next        = 1'b1;
              pulse_countdown_next = (gate_pulse_us == 14'd0) ? 14'd1 : gate_pulse_us;
              pending_flag_next    = 1'b0;
            end
          end
        end
        REQ_EDGE: begin
          since_last_edge_next = '0;
          seen_edge_next       = 1'b1;
          if (!ignore_edge) begin
            accepted_next = 1'b1;
            if (running_flag && (delay_value < half)) begin
              delay_countdown_next = delay_value;
              pending_flag_next    = 1'b1;
            end
          end
        end
        REQ_START: begin
          running_flag_next = 1'b1;
        end
        REQ_STOP: begin
          // pending fire and pulse countdown keep going
          if (running_flag) begin
            running_flag_next = 1'b0;
            gate_out_next     = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      out_valid       <= 1'b0;
      mains_sixty_hz  <= 1'b0;
      gate_pulse_us   <= RST_GATE_PULSE_US;
      min_percent     <= RST_MIN_PERCENT;
      max_percent     <= RST_MAX_PERCENT;
      max_speed_rpm   <= RST_MAX_SPEED_RPM;
      running_flag    <= 1'b0;
      delay_value     <= '0;
      since_last_edge <= '0;
      seen_edge       <= 1'b0;
      delay_countdown <= '0;
      pending_flag    <= 1'b0;
      pulse_countdown <= '0;
      gate_out        <= 1'b0;
      accepted        <= 1'b0;
    end else begin
      running_flag    <= running_flag_next;
      since_last_edge <= since_last_edge_next;
      seen_edge       <= seen_edge_next;
      delay_countdown <= delay_countdown_next;
      pending_flag    <= pending_flag_next;
      pulse_countdown <= pulse_countdown_next;
      gate_out        <= gate_out_next;
      accepted        <= accepted_next;

      // result word handshake
      if (in_acc) begin
        out_valid <= (req_type != REQ_SET);
      end else if (state == S_CAP) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MAINS_SIXTY_HZ: mains_sixty_hz <= cfg_data[0];
          CFG_GATE_PULSE_US:  gate_pulse_us  <= cfg_data[13:0];
          CFG_MIN_PERCENT:    min_percent    <= cfg_data[14:0];
          CFG_MAX_PERCENT:    max_percent    <= cfg_data[14:0];
          CFG_MAX_SPEED_RPM:  max_speed_rpm  <= cfg_data;
          default: begin
          end
        endcase
      end

      case (state)
        S_IDLE: begin
          if (in_acc && (req_type == REQ_SET)) begin
            rpm   <= target_speed_rpm;
            state <= S_PMUL;
          end
        end
        S_PMUL: begin
          prod  <= mul_p;
          state <= S_PDIV;
        end
        S_PDIV: begin
          state <= S_PWAIT;
        end
        S_PWAIT: begin
          if (div_stat.done) begin
            p_clamp <= p_hi[14:0];
            state   <= S_XDIV;
          end
        end
        S_XDIV: begin
          if (span_ok) begin
            state <= S_XWAIT;
          end else begin
            x     <= X_ONE;
            state <= S_SQ;
          end
        end
        S_XWAIT: begin
          if (div_stat.done) begin
            // quotient never exceeds 1.0 since the percent is clamped
            x     <= div_quo[16:0];
            state <= S_SQ;
          end
        end
        S_SQ: begin
          prod  <= mul_p;
          state <= S_INV;
        end
        S_INV: begin
          prod  <= mul_p;
          state <= S_CAP;
        end
        S_CAP: begin
          if (d_raw > {4'd0, cap}) begin
            delay_value <= cap;
          end else begin
            delay_value <= d_raw[13:0];
          end
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result fields are the controller state after the last word
  assign gate_level      = gate_out;
  assign is_running      = running_flag;
  assign fire_pending    = pending_flag;
  assign firing_delay_us = delay_value;
  assign edge_accepted   = accepted;

`ifndef SYNTHESIS
  // no input word is taken while the mapping sequencer is busy
  a_busy_stalls: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> in_stall)
    else $error("input taken while sequencer busy");

  // the divider is never restarted mid-division
  a_div_free: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  // the gate is only high while a pulse countdown runs
  a_gate_pulse: assert property (@(posedge clk) disable iff (rst)
    gate_out |-> (pulse_countdown != 14'd0))
    else $error("gate high with no pulse countdown");

  // finishing a set target always presents a result
  a_set_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_CAP) |=> out_valid)
    else $error("set target finished without a result");
`endif

endmodule
